/* rtl/ufrm_pkg.sv */
package ufrm_pkg;

  localparam int unsigned VERTEX_COUNT = 1024;
  localparam int unsigned VTX_W        = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned ST_W         = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNION = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

  localparam logic [ST_W-1:0] ST_MERGED = 2'd0;
  localparam logic [ST_W-1:0] ST_SAME   = 2'd1;
  localparam logic [ST_W-1:0] ST_BOTH   = 2'd2;
  localparam logic [ST_W-1:0] ST_DONE   = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SWEEP,
    CMD_MARK,
    CMD_RD_RA,
    CMD_RD_RB,
    CMD_INFO_A,
    CMD_INFO_B,
    CMD_DECIDE,
    CMD_QRES,
    CMD_WALK0,
    CMD_WALK,
    CMD_SPL_RD,
    CMD_SPL_W1,
    CMD_SPL_W2,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic sweep_last;
    logic same_root;
    logic both_restr;
    logic walk_end;
    logic out_free;
  } stat_t;

endpackage

/* rtl/union_find_restricted_merge.sv */
// Disjoint-set table over 1024 vertices, union by size with restricted roots.
// Input channel s_axis_*: tuser = request kind (clear, mark, union, query),
// tdata = vertex_a, vertex_b. One result word per request on m_axis_*:
// tuser = status, tdata = survivor root, absorbed root, group size, minimum flag.
// cfg_* writes min_group_size (reset 2); write it only while the block is idle.
// One request is in flight at a time; s_axis_tready is high only when idle.
// A merge relabels the absorbed component one member per cycle, bounded by the
// root-table write port; a clear rewrites one entry per cycle over the four tables.
// After reset a clearing pass over all 1024 entries runs before the first request
// is taken; configuration writes are accepted during it.
// The result sits in an output register; if the receiver stalls, the block holds
// the finished result and stays busy until the word in the output register is taken.
module union_find_restricted_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] vertex_a, [19:10] vertex_b, pad
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] survivor_root, [19:10] absorbed_root,
                                      // [30:20] group_size, [31] meets_minimum
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i      // min_group_size
);

  ufrm_pkg::cmd_e  cmd;
  ufrm_pkg::stat_t stat;
  logic            in_ready;
  logic [ufrm_pkg::ST_W-1:0]  out_status;
  logic [ufrm_pkg::VTX_W-1:0] out_surv, out_gone;
  logic [ufrm_pkg::CNT_W-1:0] out_size;
  logic                       out_meets;

  ufrm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ufrm_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_a_i       (s_axis_tdata[9:0]),
    .in_b_i       (s_axis_tdata[19:10]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_surv_o   (out_surv),
    .out_gone_o   (out_gone),
    .out_size_o   (out_size),
    .out_meets_o  (out_meets)
  );

  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {out_meets, out_size, out_gone, out_surv};

endmodule

/* rtl/ufrm_ram.sv */
module ufrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ufrm_ctrl.sv */
module ufrm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ufrm_pkg::REQ_W-1:0]  in_kind_i,
  output logic                        in_ready_o,
  input  ufrm_pkg::stat_t             stat_i,
  output ufrm_pkg::cmd_e              cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_MARK,
    S_RA,
    S_RB,
    S_INFO_A,
    S_INFO_B,
    S_DECIDE,
    S_QRES,
    S_WALK0,
    S_WALK,
    S_SPL_RD,
    S_SPL_W1,
    S_SPL_W2,
    S_EMIT
  } state_e;

  state_e                       state_q;
  logic [ufrm_pkg::REQ_W-1:0]   kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      kind_q  <= ufrm_pkg::REQ_CLEAR;
    end else begin
      case (state_q)
        S_INIT: begin
          if (stat_i.sweep_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= in_kind_i;
            case (in_kind_i)
              ufrm_pkg::REQ_CLEAR: state_q <= S_CLR;
              ufrm_pkg::REQ_MARK:  state_q <= S_MARK;
              default:             state_q <= S_RA;
            endcase
          end
        end
        S_CLR: begin
          if (stat_i.sweep_last) state_q <= S_EMIT;
        end
        S_MARK:   state_q <= S_EMIT;
        S_RA:     state_q <= S_RB;
        S_RB:     state_q <= S_INFO_A;
        S_INFO_A: state_q <= (kind_q == ufrm_pkg::REQ_QUERY) ? S_QRES : S_INFO_B;
        S_INFO_B: state_q <= S_DECIDE;
        S_QRES:   state_q <= S_EMIT;
        S_DECIDE: begin
          if (stat_i.same_root || stat_i.both_restr) state_q <= S_EMIT;
          else state_q <= S_WALK0;
        end
        S_WALK0:  state_q <= S_WALK;
        S_WALK: begin
          if (stat_i.walk_end) state_q <= S_SPL_RD;
        end
        S_SPL_RD: state_q <= S_SPL_W1;
        S_SPL_W1: state_q <= S_SPL_W2;
        S_SPL_W2: state_q <= S_EMIT;
        S_EMIT: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_INIT, S_CLR: cmd_o = ufrm_pkg::CMD_SWEEP;
      S_IDLE:        cmd_o = in_valid_i ? ufrm_pkg::CMD_CAPTURE : ufrm_pkg::CMD_NONE;
      S_MARK:        cmd_o = ufrm_pkg::CMD_MARK;
      S_RA:          cmd_o = ufrm_pkg::CMD_RD_RA;
      S_RB:          cmd_o = ufrm_pkg::CMD_RD_RB;
      S_INFO_A:      cmd_o = ufrm_pkg::CMD_INFO_A;
      S_INFO_B:      cmd_o = ufrm_pkg::CMD_INFO_B;
      S_DECIDE:      cmd_o = ufrm_pkg::CMD_DECIDE;
      S_QRES:        cmd_o = ufrm_pkg::CMD_QRES;
      S_WALK0:       cmd_o = ufrm_pkg::CMD_WALK0;
      S_WALK:        cmd_o = ufrm_pkg::CMD_WALK;
      S_SPL_RD:      cmd_o = ufrm_pkg::CMD_SPL_RD;
      S_SPL_W1:      cmd_o = ufrm_pkg::CMD_SPL_W1;
      S_SPL_W2:      cmd_o = ufrm_pkg::CMD_SPL_W2;
      S_EMIT:        cmd_o = stat_i.out_free ? ufrm_pkg::CMD_EMIT : ufrm_pkg::CMD_NONE;
      default:       cmd_o = ufrm_pkg::CMD_NONE;
    endcase
  end

endmodule

/* rtl/ufrm_dp.sv */
module ufrm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ufrm_pkg::cmd_e              cmd_i,
  output ufrm_pkg::stat_t             stat_o,
  input  logic [ufrm_pkg::VTX_W-1:0]  in_a_i,
  input  logic [ufrm_pkg::VTX_W-1:0]  in_b_i,
  input  logic                        cfg_we_i,
  input  logic [ufrm_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ufrm_pkg::ST_W-1:0]   out_status_o,
  output logic [ufrm_pkg::VTX_W-1:0]  out_surv_o,
  output logic [ufrm_pkg::VTX_W-1:0]  out_gone_o,
  output logic [ufrm_pkg::CNT_W-1:0]  out_size_o,
  output logic                        out_meets_o
);

  localparam int unsigned VW = ufrm_pkg::VTX_W;
  localparam int unsigned CW = ufrm_pkg::CNT_W;
  localparam int unsigned ST_W_L = ufrm_pkg::ST_W;
  localparam logic [VW-1:0] LAST_V = VW'(ufrm_pkg::VERTEX_COUNT - 1);

  // memory ports
  logic          r_we, c_we, n_we, x_we;
  logic [VW-1:0] r_waddr, c_waddr, n_waddr, x_waddr;
  logic [VW-1:0] r_raddr, c_raddr, n_raddr, x_raddr;
  logic [VW-1:0] r_wdata, n_wdata;
  logic [CW-1:0] c_wdata;
  logic          x_wdata;
  logic [VW-1:0] root_rd, nxt_rd;
  logic [CW-1:0] cnt_rd;
  logic          rst_rd;

  logic [VW-1:0] a_q, b_q, ra_q, rb_q, surv_q, gone_q, gnext_q, snext_q, clr_q;
  logic [CW-1:0] ca_q, cs_q, cg_q, min_q;
  logic          xa_q, first_q;

  logic [ST_W_L-1:0] res_st_q;
  logic [VW-1:0] res_surv_q, res_gone_q;
  logic [CW-1:0] res_size_q;
  logic          res_meets_q;

  logic          out_valid_q;
  logic [ST_W_L-1:0] out_st_q;
  logic [VW-1:0] out_surv_q, out_gone_q;
  logic [CW-1:0] out_size_q;
  logic          out_meets_q;

  logic          a_wins;
  logic [CW-1:0] sum;

  ufrm_ram #(.WIDTH(VW), .DEPTH(ufrm_pkg::VERTEX_COUNT)) u_root (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(root_rd)
  );
  ufrm_ram #(.WIDTH(CW), .DEPTH(ufrm_pkg::VERTEX_COUNT)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(cnt_rd)
  );
  ufrm_ram #(.WIDTH(VW), .DEPTH(ufrm_pkg::VERTEX_COUNT)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(nxt_rd)
  );
  ufrm_ram #(.WIDTH(1), .DEPTH(ufrm_pkg::VERTEX_COUNT)) u_restr (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(x_raddr), .rdata_o(rst_rd)
  );

  // restricted root wins; otherwise strictly larger a wins, ties to b
  assign a_wins = xa_q || (!rst_rd && (ca_q > cnt_rd));
  assign sum    = cs_q + cg_q;

  assign stat_o.sweep_last = (clr_q == LAST_V);
  assign stat_o.same_root  = (ra_q == rb_q);
  assign stat_o.both_restr = xa_q && rst_rd;
  assign stat_o.walk_end   = (nxt_rd == gone_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    r_we = 1'b0; c_we = 1'b0; n_we = 1'b0; x_we = 1'b0;
    r_waddr = '0; c_waddr = '0; n_waddr = '0; x_waddr = '0;
    r_raddr = '0; c_raddr = '0; n_raddr = '0; x_raddr = '0;
    r_wdata = '0; n_wdata = '0; c_wdata = '0; x_wdata = 1'b0;
    case (cmd_i)
      ufrm_pkg::CMD_SWEEP: begin
        r_we = 1'b1; c_we = 1'b1; n_we = 1'b1; x_we = 1'b1;
        r_waddr = clr_q; c_waddr = clr_q; n_waddr = clr_q; x_waddr = clr_q;
        r_wdata = clr_q; n_wdata = clr_q; c_wdata = CW'(1); x_wdata = 1'b0;
      end
      ufrm_pkg::CMD_MARK: begin
        x_we = 1'b1; x_waddr = a_q; x_wdata = 1'b1;
      end
      ufrm_pkg::CMD_RD_RA: r_raddr = a_q;
      ufrm_pkg::CMD_RD_RB: r_raddr = b_q;
      ufrm_pkg::CMD_INFO_A: begin
        c_raddr = ra_q; x_raddr = ra_q;
      end
      ufrm_pkg::CMD_INFO_B: begin
        c_raddr = rb_q; x_raddr = rb_q;
      end
      ufrm_pkg::CMD_WALK0: begin
        r_we = 1'b1; r_waddr = gone_q; r_wdata = surv_q;
        n_raddr = gone_q;
      end
      ufrm_pkg::CMD_WALK: begin
        r_we = !stat_o.walk_end; r_waddr = nxt_rd; r_wdata = surv_q;
        n_raddr = nxt_rd;
      end
      ufrm_pkg::CMD_SPL_RD: n_raddr = surv_q;
      ufrm_pkg::CMD_SPL_W1: begin
        n_we = 1'b1; n_waddr = surv_q; n_wdata = gnext_q;
      end
      ufrm_pkg::CMD_SPL_W2: begin
        n_we = 1'b1; n_waddr = gone_q; n_wdata = snext_q;
        c_we = 1'b1; c_waddr = surv_q; c_wdata = sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      min_q       <= CW'(2);
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (cfg_we_i) min_q <= cfg_data_i;
      if (cmd_i == ufrm_pkg::CMD_SWEEP) begin
        clr_q <= stat_o.sweep_last ? '0 : clr_q + VW'(1);
      end
      if (cmd_i == ufrm_pkg::CMD_WALK0) first_q <= 1'b1;
      else if (cmd_i == ufrm_pkg::CMD_WALK) first_q <= 1'b0;
      if (cmd_i == ufrm_pkg::CMD_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      ufrm_pkg::CMD_CAPTURE: begin
        a_q <= in_a_i;
        b_q <= in_b_i;
      end
      ufrm_pkg::CMD_SWEEP, ufrm_pkg::CMD_MARK: begin
        res_st_q    <= ufrm_pkg::ST_DONE;
        res_surv_q  <= '0;
        res_gone_q  <= '0;
        res_size_q  <= '0;
        res_meets_q <= 1'b0;
      end
      ufrm_pkg::CMD_RD_RB: ra_q <= root_rd;
      ufrm_pkg::CMD_INFO_A: rb_q <= root_rd;
      ufrm_pkg::CMD_INFO_B: begin
        ca_q <= cnt_rd;
        xa_q <= rst_rd;
      end
      ufrm_pkg::CMD_QRES: begin
        res_st_q    <= ufrm_pkg::ST_DONE;
        res_surv_q  <= ra_q;
        res_gone_q  <= '0;
        res_size_q  <= cnt_rd;
        res_meets_q <= (cnt_rd >= min_q);
      end
      ufrm_pkg::CMD_DECIDE: begin
        if (stat_o.same_root) begin
          res_st_q    <= ufrm_pkg::ST_SAME;
          res_surv_q  <= ra_q;
          res_size_q  <= ca_q;
          res_meets_q <= (ca_q >= min_q);
        end else begin
          res_st_q    <= ufrm_pkg::ST_BOTH;
          res_surv_q  <= '0;
          res_size_q  <= '0;
          res_meets_q <= 1'b0;
        end
        res_gone_q <= '0;
        surv_q <= a_wins ? ra_q : rb_q;
        gone_q <= a_wins ? rb_q : ra_q;
        cs_q   <= a_wins ? ca_q : cnt_rd;
        cg_q   <= a_wins ? cnt_rd : ca_q;
      end
      ufrm_pkg::CMD_WALK: begin
        if (first_q) gnext_q <= nxt_rd;
      end
      ufrm_pkg::CMD_SPL_W1: snext_q <= nxt_rd;
      ufrm_pkg::CMD_SPL_W2: begin
        res_st_q    <= ufrm_pkg::ST_MERGED;
        res_surv_q  <= surv_q;
        res_gone_q  <= gone_q;
        res_size_q  <= sum;
        res_meets_q <= (sum >= min_q);
      end
      ufrm_pkg::CMD_EMIT: begin
        out_st_q    <= res_st_q;
        out_surv_q  <= res_surv_q;
        out_gone_q  <= res_gone_q;
        out_size_q  <= res_size_q;
        out_meets_q <= res_meets_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_surv_o   = out_surv_q;
  assign out_gone_o   = out_gone_q;
  assign out_size_o   = out_size_q;
  assign out_meets_o  = out_meets_q;

endmodule

/* test/union_find_restricted_merge_tb.sv */
`timescale 1ns / 1ps

module union_find_restricted_merge_tb;
  import ufrm_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VTX_W-1:0] survivor;
    logic [VTX_W-1:0] absorbed;
    logic [CNT_W-1:0] size;
    logic             meets;
  } outcome_t;

  class partition_tracker;
    logic [VTX_W-1:0] root_of [VERTEX_COUNT];
    logic [CNT_W-1:0] size_of [VERTEX_COUNT];
    logic [VTX_W-1:0] next_member [VERTEX_COUNT];
    bit               flagged [VERTEX_COUNT];
    logic [CNT_W-1:0] min_size;
    outcome_t         pending_results [$];
    int               mismatches;

    function new();
      min_size   = 11'd2;
      mismatches = 0;
      reset_table();
    endfunction

    function void reset_table();
      for (int v = 0; v < VERTEX_COUNT; v++) begin
        root_of[v]     = VTX_W'(v);
        size_of[v]     = 11'd1;
        next_member[v] = VTX_W'(v);
        flagged[v]     = 1'b0;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [VTX_W-1:0] a,
                               logic [VTX_W-1:0] b);
      outcome_t         r;
      logic [VTX_W-1:0] ra, rb, keep, drop, walk, tmp;
      r = '0;
      r.status = ST_DONE;
      ra = root_of[a];
      rb = root_of[b];
      case (kind)
        REQ_CLEAR: reset_table();
        REQ_MARK:  flagged[a] = 1'b1;
        REQ_QUERY: begin
          r.survivor = ra;
          r.size     = size_of[ra];
          r.meets    = size_of[ra] >= min_size;
        end
        default: begin
          if (ra == rb) begin
            r.status   = ST_SAME;
            r.survivor = ra;
            r.size     = size_of[ra];
            r.meets    = size_of[ra] >= min_size;
          end else if (flagged[ra] && flagged[rb]) begin
            r.status = ST_BOTH;
          end else begin
            if (flagged[ra]) begin
              keep = ra; drop = rb;
            end else if (flagged[rb]) begin
              keep = rb; drop = ra;
            end else if (size_of[ra] > size_of[rb]) begin
              keep = ra; drop = rb;
            end else begin
              keep = rb; drop = ra;
            end
            walk = drop;
            do begin
              root_of[walk] = keep;
              walk = next_member[walk];
            end while (walk != drop);
            tmp               = next_member[keep];
            next_member[keep] = next_member[drop];
            next_member[drop] = tmp;
            size_of[keep]     = size_of[keep] + size_of[drop];
            r.status   = ST_MERGED;
            r.survivor = keep;
            r.absorbed = drop;
            r.size     = size_of[keep];
            r.meets    = size_of[keep] >= min_size;
          end
        end
      endcase
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(logic [ST_W-1:0] status, logic [31:0] data);
      outcome_t got, want;
      got.status   = status;
      got.survivor = data[9:0];
      got.absorbed = data[19:10];
      got.size     = data[30:20];
      got.meets    = data[31];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word st=%0d surv=%0d abs=%0d size=%0d min=%0b",
                   $realtime, got.status, got.survivor, got.absorbed, got.size, got.meets);
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status || got.survivor != want.survivor ||
          got.absorbed != want.absorbed || got.size != want.size ||
          got.meets != want.meets) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result mismatch exp st=%0d surv=%0d abs=%0d size=%0d min=%0b",
                    " / act st=%0d surv=%0d abs=%0d size=%0d min=%0b"}, $realtime,
                   want.status, want.survivor, want.absorbed, want.size, want.meets,
                   got.status, got.survivor, got.absorbed, got.size, got.meets);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;

  partition_tracker sb = new();

  int               send_idle_pct = 8;
  int               recv_idle_pct = 79;
  int               hold_request = 0;
  int               hold_left = 0;
  logic [VTX_W-1:0] pool_base = '0;
  int               pool_span = 32;

  union_find_restricted_merge DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // monitor: every word accepted at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10]);
    end
  end

  // receiver: random stalls, plus long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] kind, logic [VTX_W-1:0] a,
                              logic [VTX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {4'b0, 20'($urandom)};
      s_axis_tuser  <= 2'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b, a};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic write_min_size(logic [CNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.min_size = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    int               pick;
    logic [VTX_W-1:0] a, b;
    pick = $urandom_range(99);
    if (pick >= 98) begin
      pool_base = VTX_W'($urandom);
      case ($urandom_range(2))
        0:       pool_span = 8;
        1:       pool_span = 32;
        default: pool_span = 256;
      endcase
    end
    a = pool_base + VTX_W'($urandom_range(pool_span - 1));
    b = pool_base + VTX_W'($urandom_range(pool_span - 1));
    if (pick < 55 || pick >= 98)
      send_request(REQ_UNION, a, b);
    else if (pick < 73)
      send_request(REQ_QUERY, a, VTX_W'($urandom));
    else if (pick < 78)
      send_request(REQ_MARK, a, VTX_W'($urandom));
    else if (pick < 88)
      send_request(REQ_UNION, VTX_W'($urandom), VTX_W'($urandom));
    else if (pick < 97)
      send_request(REQ_QUERY, VTX_W'($urandom), VTX_W'($urandom));
    else
      send_request(REQ_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct, logic [CNT_W-1:0] min_size,
                           bit long_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_min_size(min_size);
    if (long_hold) hold_request = 400;
    repeat (n) random_item();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_min_size(11'd3);

    // directed
    send_request(REQ_QUERY, 10'd0, 10'd1023);
    send_request(REQ_QUERY, 10'd1023, 10'd0);
    send_request(REQ_UNION, 10'd0, 10'd1023);
    send_request(REQ_UNION, 10'd1023, 10'd0);
    send_request(REQ_UNION, 10'd5, 10'd6);
    send_request(REQ_UNION, 10'd7, 10'd6);
    send_request(REQ_UNION, 10'd6, 10'd8);
    send_request(REQ_MARK, 10'd9, 10'd0);
    send_request(REQ_UNION, 10'd6, 10'd9);     // restricted second root survives
    send_request(REQ_MARK, 10'd10, 10'd1023);
    send_request(REQ_UNION, 10'd10, 10'd11);   // restricted first root survives
    send_request(REQ_UNION, 10'd9, 10'd10);    // both restricted
    send_request(REQ_MARK, 10'd1023, 10'd0);
    send_request(REQ_UNION, 10'd0, 10'd9);
    send_request(REQ_MARK, 10'd7, 10'd0);      // non-root flag
    send_request(REQ_QUERY, 10'd7, 10'd0);
    send_request(REQ_UNION, 10'h155, 10'h2aa);
    send_request(REQ_UNION, 10'h2aa, 10'h155);
    send_request(REQ_QUERY, 10'd512, 10'd511);
    send_request(REQ_CLEAR, 10'd1023, 10'd1023);
    send_request(REQ_QUERY, 10'd9, 10'd0);
    send_request(REQ_UNION, 10'd9, 10'd10);
    send_request(REQ_MARK, 10'd0, 10'd0);
    send_request(REQ_UNION, 10'd1, 10'd0);
    wait_drained();

    run_phase(190, 8, 79, 11'd1, 1'b0);
    run_phase(190, 79, 8, 11'd1024, 1'b0);
    run_phase(190, 0, 0, 11'd0, 1'b1);
    run_phase(190, 0, 0, CNT_W'($urandom_range(2, 12)), 1'b0);

    repeat (40) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/ufrm_pkg.sv
rtl/ufrm_ram.sv
rtl/ufrm_ctrl.sv
rtl/ufrm_dp.sv
rtl/union_find_restricted_merge.sv
test/union_find_restricted_merge_tb.sv
